// ----- rtl/opl_pkg.sv -----
// Shared constants, types and helpers for the ordered play list table.
package opl_pkg;

	localparam int LIST_DEPTH = 16;
	localparam int SLOT_W     = $clog2(LIST_DEPTH);
	// Holds up to LIST_DEPTH-1 entries, so the slot width is wide enough.
	localparam int CNT_W      = $clog2(LIST_DEPTH);

	localparam int FUNC_W     = 2;
	localparam int SEG_W      = 16;
	localparam int INTV_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int STATUS_W   = 2;
	localparam int CNT_OUT_W  = 4;

	localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE,
		ST_FULL,
		ST_EMPTY,
		ST_NOT_FOUND
	} status_t;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_DELETE,
		OP_CLEAR,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [SEG_W-1:0]  seg;
		logic [INTV_W-1:0] intv;
		logic [BYTE_W-1:0] times;
		logic [BYTE_W-1:0] kind;
		logic [BYTE_W-1:0] prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		op_t    op;
		entry_t entry;
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH_LINK,
		S_SEARCH,
		S_RELEASE,
		S_HEAD_RD,
		S_REPLY
	} back_state_t;

	// Link of a slot whose link was never written: the next slot, wrapping to zero.
	function automatic logic [SLOT_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
		reset_link = (slot == SLOT_W'(LIST_DEPTH - 1)) ? '0 : slot + 1'b1;
	endfunction

endpackage

// ----- rtl/opl_if.sv -----
// Command and response channel interfaces of the ordered play list table.
interface opl_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [opl_pkg::FUNC_W-1:0]     func;
	logic [opl_pkg::SEG_W-1:0]      seg_addr;
	logic [opl_pkg::INTV_W-1:0]     interval;
	logic [opl_pkg::BYTE_W-1:0]     repeat_times;
	logic [opl_pkg::BYTE_W-1:0]     play_kind;
	logic [opl_pkg::BYTE_W-1:0]     priority_req;

	modport source (
		output valid, func, seg_addr, interval, repeat_times, play_kind, priority_req,
		input  ready
	);
	modport sink (
		input  valid, func, seg_addr, interval, repeat_times, play_kind, priority_req,
		output ready
	);
endinterface

interface opl_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [opl_pkg::STATUS_W-1:0]   status;
	logic [opl_pkg::CNT_OUT_W-1:0]  entry_count;
	logic                           head_valid;
	logic [opl_pkg::SEG_W-1:0]      head_seg_addr;
	logic [opl_pkg::INTV_W-1:0]     head_interval;
	logic [opl_pkg::BYTE_W-1:0]     head_times;
	logic [opl_pkg::BYTE_W-1:0]     head_kind;
	logic [opl_pkg::BYTE_W-1:0]     head_priority;

	modport source (
		output valid, status, entry_count, head_valid, head_seg_addr, head_interval,
		       head_times, head_kind, head_priority,
		input  ready
	);
	modport sink (
		input  valid, status, entry_count, head_valid, head_seg_addr, head_interval,
		       head_times, head_kind, head_priority,
		output ready
	);
endinterface

// ----- rtl/opl_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
module opl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/opl_front.sv -----
// Command intake: decode each transfer into an operation and queue it for the back end.
module opl_front (
	input  logic            clk,
	input  logic            arst_n,
	opl_cmd_if.sink         cmd,
	input  logic            q_pop,
	output logic            q_valid,
	output opl_pkg::cmd_t   q_cmd
);

	opl_pkg::cmd_t                   cls_cmd;
	opl_pkg::cmd_t                   slot_q [opl_pkg::QUEUE_DEPTH];
	logic [opl_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [opl_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [opl_pkg::QCNT_W-1:0]      fill_q;
	logic                            push;
	logic                            pop;

	// Classify the command; unused codes become a no-op.
	always_comb begin
		cls_cmd.entry.seg   = cmd.seg_addr;
		cls_cmd.entry.intv  = cmd.interval;
		cls_cmd.entry.times = cmd.repeat_times;
		cls_cmd.entry.kind  = cmd.play_kind;
		cls_cmd.entry.prio  = cmd.priority_req;
		case (cmd.func)
			opl_pkg::FUNC_PUSH:   cls_cmd.op = opl_pkg::OP_PUSH;
			opl_pkg::FUNC_DELETE: cls_cmd.op = opl_pkg::OP_DELETE;
			opl_pkg::FUNC_CLEAR:  cls_cmd.op = opl_pkg::OP_CLEAR;
			default:              cls_cmd.op = opl_pkg::OP_NOP;
		endcase
	end

	assign cmd.ready = (fill_q != opl_pkg::QCNT_W'(opl_pkg::QUEUE_DEPTH));
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (fill_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == opl_pkg::QPTR_W'(opl_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == opl_pkg::QPTR_W'(opl_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls_cmd;
		end
	end

endmodule

// ----- rtl/opl_back.sv -----
// List engine: executes queued operations on the linked slot pool and issues responses.
module opl_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  opl_pkg::cmd_t   q_cmd,
	output logic            q_pop,
	opl_rsp_if.source       rsp
);

	opl_pkg::back_state_t             state_q, state_d;
	logic [opl_pkg::SLOT_W-1:0]       head_q, head_d;
	logic [opl_pkg::SLOT_W-1:0]       append_q, append_d;
	logic [opl_pkg::SLOT_W-1:0]       free_tail_q, free_tail_d;
	logic [opl_pkg::SLOT_W-1:0]       tail_q, tail_d;
	logic [opl_pkg::CNT_W-1:0]        count_q, count_d;
	logic [opl_pkg::LIST_DEPTH-1:0]   link_vld_q, link_vld_d;

	logic [opl_pkg::SLOT_W-1:0]       cur_q, cur_d;
	logic [opl_pkg::SLOT_W-1:0]       prev_q, prev_d;
	logic [opl_pkg::CNT_W-1:0]        idx_q, idx_d;
	logic [opl_pkg::SEG_W-1:0]        key_q, key_d;
	logic                             refresh_q, refresh_d;
	opl_pkg::status_t                 status_q, status_d;
	opl_pkg::entry_t                  head_ent_q, head_ent_d;

	logic [opl_pkg::SLOT_W-1:0]       rd_addr;
	logic [opl_pkg::SLOT_W-1:0]       rd_addr_q;
	logic                             rd_vld_q;

	logic                             store_we;
	logic [opl_pkg::ENTRY_W-1:0]      store_rdata;
	opl_pkg::entry_t                  store_rd;
	logic                             link_we;
	logic [opl_pkg::SLOT_W-1:0]       link_waddr;
	logic [opl_pkg::SLOT_W-1:0]       link_wdata;
	logic [opl_pkg::SLOT_W-1:0]       link_rdata;
	logic [opl_pkg::SLOT_W-1:0]       link_next;

	logic                             load_rsp;
	logic                             rsp_vld_q;
	opl_pkg::status_t                 rsp_status_q;
	logic [opl_pkg::CNT_OUT_W-1:0]    rsp_count_q;
	logic                             rsp_head_vld_q;
	opl_pkg::entry_t                  rsp_head_q;

	opl_ram #(
		.WIDTH (opl_pkg::ENTRY_W),
		.DEPTH (opl_pkg::LIST_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (append_q),
		.wdata (q_cmd.entry),
		.raddr (rd_addr),
		.rdata (store_rdata)
	);

	opl_ram #(
		.WIDTH (opl_pkg::SLOT_W),
		.DEPTH (opl_pkg::LIST_DEPTH)
	) u_links (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	assign store_rd  = store_rdata;
	// Unwritten links still hold the initial free chain.
	assign link_next = rd_vld_q ? link_rdata : opl_pkg::reset_link(rd_addr_q);

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		append_d    = append_q;
		free_tail_d = free_tail_q;
		tail_d      = tail_q;
		count_d     = count_q;
		link_vld_d  = link_vld_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		idx_d       = idx_q;
		key_d       = key_q;
		refresh_d   = refresh_q;
		status_d    = status_q;
		head_ent_d  = head_ent_q;
		rd_addr     = cur_q;
		store_we    = 1'b0;
		link_we     = 1'b0;
		link_waddr  = free_tail_q;
		link_wdata  = cur_q;
		q_pop       = 1'b0;
		load_rsp    = 1'b0;

		case (state_q)
			opl_pkg::S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					case (q_cmd.op)
						opl_pkg::OP_PUSH: begin
							if (count_q == opl_pkg::CNT_W'(opl_pkg::LIST_DEPTH - 1)) begin
								status_d = opl_pkg::ST_FULL;
								state_d  = opl_pkg::S_REPLY;
							end else begin
								store_we = 1'b1;
								rd_addr  = append_q;
								tail_d   = append_q;
								if (count_q == '0) begin
									head_ent_d = q_cmd.entry;
								end
								count_d  = count_q + 1'b1;
								status_d = opl_pkg::ST_DONE;
								state_d  = opl_pkg::S_PUSH_LINK;
							end
						end
						opl_pkg::OP_DELETE: begin
							if (count_q == '0) begin
								status_d = opl_pkg::ST_EMPTY;
								state_d  = opl_pkg::S_REPLY;
							end else begin
								key_d   = q_cmd.entry.seg;
								cur_d   = head_q;
								idx_d   = '0;
								rd_addr = head_q;
								state_d = opl_pkg::S_SEARCH;
							end
						end
						opl_pkg::OP_CLEAR: begin
							if (count_q == '0) begin
								status_d = opl_pkg::ST_EMPTY;
							end else begin
								// Splice the whole held chain onto the end of the free chain.
								link_we     = 1'b1;
								link_waddr  = free_tail_q;
								link_wdata  = head_q;
								free_tail_d = tail_q;
								head_d      = append_q;
								count_d     = '0;
								status_d    = opl_pkg::ST_DONE;
							end
							state_d = opl_pkg::S_REPLY;
						end
						default: begin
							status_d = opl_pkg::ST_DONE;
							state_d  = opl_pkg::S_REPLY;
						end
					endcase
				end
			end
			opl_pkg::S_PUSH_LINK: begin
				append_d = link_next;
				state_d  = opl_pkg::S_REPLY;
			end
			opl_pkg::S_SEARCH: begin
				if (store_rd.seg == key_q) begin
					count_d   = count_q - 1'b1;
					refresh_d = (idx_q == '0) && (count_q != opl_pkg::CNT_W'(1));
					if (idx_q == '0) begin
						head_d = link_next;
					end else begin
						link_we    = 1'b1;
						link_waddr = prev_q;
						link_wdata = link_next;
						if (cur_q == tail_q) begin
							tail_d = prev_q;
						end
					end
					status_d = opl_pkg::ST_DONE;
					state_d  = opl_pkg::S_RELEASE;
				end else if (idx_q == count_q - 1'b1) begin
					status_d = opl_pkg::ST_NOT_FOUND;
					state_d  = opl_pkg::S_REPLY;
				end else begin
					// Advance one slot along the chain.
					prev_d  = cur_q;
					cur_d   = link_next;
					idx_d   = idx_q + 1'b1;
					rd_addr = link_next;
				end
			end
			opl_pkg::S_RELEASE: begin
				link_we     = 1'b1;
				link_waddr  = free_tail_q;
				link_wdata  = cur_q;
				free_tail_d = cur_q;
				if (refresh_q) begin
					rd_addr = head_q;
					state_d = opl_pkg::S_HEAD_RD;
				end else begin
					state_d = opl_pkg::S_REPLY;
				end
			end
			opl_pkg::S_HEAD_RD: begin
				head_ent_d = store_rd;
				state_d    = opl_pkg::S_REPLY;
			end
			opl_pkg::S_REPLY: begin
				if (!rsp_vld_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = opl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = opl_pkg::S_IDLE;
			end
		endcase

		if (link_we) begin
			link_vld_d[link_waddr] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= opl_pkg::S_IDLE;
			head_q      <= '0;
			append_q    <= '0;
			free_tail_q <= opl_pkg::SLOT_W'(opl_pkg::LIST_DEPTH - 1);
			tail_q      <= '0;
			count_q     <= '0;
			link_vld_q  <= '0;
			rd_vld_q    <= 1'b0;
			rsp_vld_q   <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			append_q    <= append_d;
			free_tail_q <= free_tail_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			link_vld_q  <= link_vld_d;
			rd_vld_q    <= link_vld_q[rd_addr];
			if (load_rsp) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		prev_q     <= prev_d;
		idx_q      <= idx_d;
		key_q      <= key_d;
		refresh_q  <= refresh_d;
		status_q   <= status_d;
		head_ent_q <= head_ent_d;
		rd_addr_q  <= rd_addr;
		if (load_rsp) begin
			rsp_status_q   <= status_q;
			rsp_count_q    <= opl_pkg::CNT_OUT_W'(count_q);
			rsp_head_vld_q <= (count_q != '0);
			rsp_head_q     <= (count_q != '0) ? head_ent_q : '0;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.head_valid    = rsp_head_vld_q;
	assign rsp.head_seg_addr = rsp_head_q.seg;
	assign rsp.head_interval = rsp_head_q.intv;
	assign rsp.head_times    = rsp_head_q.times;
	assign rsp.head_kind     = rsp_head_q.kind;
	assign rsp.head_priority = rsp_head_q.prio;

`ifndef SYNTH
	a_empty_head_at_append: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == append_q))
		else $error("empty list with head apart from append slot");

	a_search_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == opl_pkg::S_SEARCH) |-> (idx_q < count_q))
		else $error("search walked past the held entries");

	a_rsp_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == opl_pkg::S_REPLY))
		else $error("response raised outside the reply step");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == opl_pkg::S_PUSH_LINK) |-> (count_q != '0))
		else $error("push completed with an empty list");
`endif

endmodule

// ----- rtl/ordered_play_list_table.sv -----
// Top level of the ordered play list table.
// Usage:
//   cmd (sink)  : valid/ready transfer of one command: func (push, delete by segment
//                 address, clear), seg_addr and the entry fields for a push.
//   rsp (source): one transfer per command: status, entry_count and the head entry,
//                 which is the current-play position; head fields read zero when empty.
// Commands pass through a two-deep queue in the front end, so the host can hand over
// the next command while the engine works or a response waits to be taken.
// A command is popped in the idle step; an accepted push then passes the link step, and
// every command ends in the reply step. A delete walks one held entry per cycle through
// the single read port of the entry store RAM and, on a match, releases the slot and
// rereads the head entry when a new head moved up. The engine handles one command at a
// time, so a delete walk over many held entries holds back the commands queued behind it.
// Reset: the list is empty, slots form one free chain in slot order; no clearing pass
// is needed, a valid bit per link marks which links have been rewritten.
// Receiver stall: the response register holds its transfer; the engine waits in its
// reply step, and the queue keeps taking commands until both entries are full.
module ordered_play_list_table (
	input  logic        clk,
	input  logic        arst_n,
	opl_cmd_if.sink     cmd,
	opl_rsp_if.source   rsp
);

	// Queue hand-off between the intake and the list engine.
	logic               q_valid;
	logic               q_pop;
	opl_pkg::cmd_t      q_cmd;

	// Decode and buffer commands.
	opl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	// Execute list operations and drive responses.
	opl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

// ----- verif/ordered_play_list_table_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the ordered play list table: directed and random commands.
module ordered_play_list_table_tb;
	import opl_pkg::*;

	// One response transfer, as the block reports it.
	typedef struct packed {
		status_t                status;
		logic [CNT_OUT_W-1:0]   count;
		logic                   head_valid;
		entry_t                 head;
	} play_reply_t;

	// Mirror of the slot pool: entry words, per-slot links, the head, the append slot
	// (start of the free chain), the free chain tail and the number of held entries.
	class play_list_mirror;
		entry_t            slot_entry[LIST_DEPTH];
		logic [SLOT_W-1:0] next_slot[LIST_DEPTH];
		logic [SLOT_W-1:0] head;
		logic [SLOT_W-1:0] append;
		logic [SLOT_W-1:0] free_tail;
		int                held;
		play_reply_t       replies_due[$];
		int                mismatch_count;

		function new();
			for (int i = 0; i < LIST_DEPTH; i++) begin
				slot_entry[i] = '0;
				next_slot[i]  = SLOT_W'((i + 1) % LIST_DEPTH);
			end
			head           = '0;
			append         = '0;
			free_tail      = SLOT_W'(LIST_DEPTH - 1);
			held           = 0;
			mismatch_count = 0;
		endfunction

		// Zero the slot and hang it on the end of the free chain.
		function void release_slot(logic [SLOT_W-1:0] s);
			slot_entry[s]        = '0;
			next_slot[s]         = '0;
			next_slot[free_tail] = s;
			free_tail            = s;
		endfunction

		function status_t push_entry(entry_t e);
			logic [SLOT_W-1:0] s;
			if (held >= LIST_DEPTH - 1)
				return ST_FULL;
			s             = append;
			slot_entry[s] = e;
			append        = next_slot[s];
			held++;
			return ST_DONE;
		endfunction

		function status_t delete_entry(logic [SEG_W-1:0] key);
			logic [SLOT_W-1:0] cur;
			logic [SLOT_W-1:0] prev;
			if (held == 0)
				return ST_EMPTY;
			cur  = head;
			prev = '0;
			for (int i = 0; i < held; i++) begin
				if (slot_entry[cur].seg == key) begin
					if (i == 0)
						head = next_slot[cur];
					else
						next_slot[prev] = next_slot[cur];
					release_slot(cur);
					held--;
					return ST_DONE;
				end
				prev = cur;
				cur  = next_slot[cur];
			end
			return ST_NOT_FOUND;
		endfunction

		function status_t clear_all();
			logic [SLOT_W-1:0] cur;
			logic [SLOT_W-1:0] nxt;
			if (held == 0)
				return ST_EMPTY;
			cur = head;
			for (int i = 0; i < held; i++) begin
				nxt = next_slot[cur];
				release_slot(cur);
				cur = nxt;
			end
			head = append;
			held = 0;
			return ST_DONE;
		endfunction

		// Segment address of the idx-th held entry, counted from the head.
		function logic [SEG_W-1:0] held_seg(int idx);
			logic [SLOT_W-1:0] cur;
			cur = head;
			for (int i = 0; i < idx; i++)
				cur = next_slot[cur];
			return slot_entry[cur].seg;
		endfunction

		// Apply one accepted command and queue the response it must produce.
		function void take_command(op_t op, entry_t e);
			play_reply_t r;
			case (op)
				OP_PUSH:   r.status = push_entry(e);
				OP_DELETE: r.status = delete_entry(e.seg);
				OP_CLEAR:  r.status = clear_all();
				default:   r.status = ST_DONE;
			endcase
			r.count      = CNT_OUT_W'(held);
			r.head_valid = (held != 0);
			r.head       = (held != 0) ? slot_entry[head] : '0;
			replies_due.push_back(r);
		endfunction

		function void check_reply(play_reply_t got);
			play_reply_t want;
			if (replies_due.size() == 0) begin
				$error("response transfer with no command outstanding");
				mismatch_count++;
				return;
			end
			want = replies_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatch_count++;
			end
			if (got.count !== want.count) begin
				$error("entry_count: expected %0d, got %0d", want.count, got.count);
				mismatch_count++;
			end
			if (got.head_valid !== want.head_valid) begin
				$error("head_valid: expected %0b, got %0b", want.head_valid, got.head_valid);
				mismatch_count++;
			end
			if (got.head.seg !== want.head.seg) begin
				$error("head_seg_addr: expected %h, got %h", want.head.seg, got.head.seg);
				mismatch_count++;
			end
			if (got.head.intv !== want.head.intv) begin
				$error("head_interval: expected %h, got %h", want.head.intv, got.head.intv);
				mismatch_count++;
			end
			if (got.head.times !== want.head.times) begin
				$error("head_times: expected %h, got %h", want.head.times, got.head.times);
				mismatch_count++;
			end
			if (got.head.kind !== want.head.kind) begin
				$error("head_kind: expected %h, got %h", want.head.kind, got.head.kind);
				mismatch_count++;
			end
			if (got.head.prio !== want.head.prio) begin
				$error("head_priority: expected %h, got %h", want.head.prio, got.head.prio);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	opl_cmd_if cmd_bus ();
	opl_rsp_if rsp_bus ();

	ordered_play_list_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus.sink),
		.rsp    (rsp_bus.source)
	);

	play_list_mirror playlist = new();

	// Per-cycle idle chances, in percent, of the command side and the response side.
	int unsigned cmd_idle_pct = 0;
	int unsigned rsp_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run of the whole sequence.
	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

	// Response side: decide the stall at the falling edge, so ready is stable at the
	// rising edge where the transfer is sampled.
	initial begin
		rsp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	// Check every response transfer against the oldest queued expectation.
	always @(posedge clk) begin
		play_reply_t got;
		if (arst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
			got.status     = status_t'(rsp_bus.status);
			got.count      = rsp_bus.entry_count;
			got.head_valid = rsp_bus.head_valid;
			got.head.seg   = rsp_bus.head_seg_addr;
			got.head.intv  = rsp_bus.head_interval;
			got.head.times = rsp_bus.head_times;
			got.head.kind  = rsp_bus.head_kind;
			got.head.prio  = rsp_bus.head_priority;
			playlist.check_reply(got);
		end
	end

	// Present one command from a falling edge, hold it until its transfer, note it in the
	// mirror and return at the next falling edge with valid still high.
	task automatic send_command(input op_t op, input entry_t e);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.func         <= op;
		cmd_bus.seg_addr     <= e.seg;
		cmd_bus.interval     <= e.intv;
		cmd_bus.repeat_times <= e.times;
		cmd_bus.play_kind    <= e.kind;
		cmd_bus.priority_req <= e.prio;
		do
			@(posedge clk);
		while (cmd_bus.ready !== 1'b1);
		playlist.take_command(op, e);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every queued response has come back.
	task automatic wait_replies_drained();
		cmd_bus.valid <= 1'b0;
		@(negedge clk);
		while (playlist.replies_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic entry_t make_entry(logic [SEG_W-1:0] seg, logic [INTV_W-1:0] intv,
			logic [BYTE_W-1:0] times, logic [BYTE_W-1:0] kind, logic [BYTE_W-1:0] prio);
		entry_t e;
		e.seg   = seg;
		e.intv  = intv;
		e.times = times;
		e.kind  = kind;
		e.prio  = prio;
		return e;
	endfunction

	task automatic directed_commands();
		// Empty list: delete and clear report empty, the unused code reports done.
		send_command(OP_DELETE, make_entry(16'h0000, '0, '0, '0, '0));
		send_command(OP_CLEAR, '0);
		send_command(OP_NOP, '0);
		// Extremes of every field, plus a duplicate segment address.
		send_command(OP_PUSH, make_entry(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_command(OP_PUSH, make_entry(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_command(OP_PUSH, make_entry(16'h0000, 16'hA5A5, 8'h5A, 8'hC3, 8'h3C));
		// Delete must take the first match only; then a key that is not held.
		send_command(OP_DELETE, make_entry(16'h0000, '0, '0, '0, '0));
		send_command(OP_DELETE, make_entry(16'h1234, '0, '0, '0, '0));
		send_command(OP_NOP, '0);
		// Remove the head so the next entry moves up to the play position.
		send_command(OP_DELETE, make_entry(16'hFFFF, '0, '0, '0, '0));
		// Fill to the limit, then one push past it.
		for (int i = 1; i <= LIST_DEPTH - 2; i++)
			send_command(OP_PUSH, make_entry(SEG_W'(i), INTV_W'(i * 257), BYTE_W'(i),
				BYTE_W'(255 - i), BYTE_W'(i * 3)));
		send_command(OP_PUSH, make_entry(16'hBEEF, 16'h1111, 8'h22, 8'h33, 8'h44));
		send_command(OP_DELETE, make_entry(16'h0007, '0, '0, '0, '0));
		send_command(OP_CLEAR, '0);
		send_command(OP_DELETE, make_entry(16'h0001, '0, '0, '0, '0));
	endtask

	// Random traffic that swings the list between filling up and draining, so full,
	// empty, reused slots and deletes at every depth all come around.
	task automatic random_commands(input int n);
		bit          growing;
		int unsigned pick;
		int unsigned push_pct;
		int unsigned delete_pct;
		op_t         op;
		entry_t      e;
		growing = 1'b1;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(39) == 0 || playlist.held == 0)
				growing = (playlist.held == 0) ? 1'b1 : ~growing;
			push_pct   = growing ? 75 : 25;
			delete_pct = growing ? 18 : 67;
			pick       = $urandom_range(99);
			if (pick < push_pct)
				op = OP_PUSH;
			else if (pick < push_pct + delete_pct)
				op = OP_DELETE;
			else if (pick < 97)
				op = OP_CLEAR;
			else
				op = OP_NOP;
			e.seg   = SEG_W'($urandom);
			e.intv  = INTV_W'($urandom);
			e.times = BYTE_W'($urandom);
			e.kind  = BYTE_W'($urandom);
			e.prio  = BYTE_W'($urandom);
			pick    = $urandom_range(99);
			if (op == OP_DELETE && playlist.held != 0 && pick < 75)
				e.seg = playlist.held_seg($urandom_range(playlist.held - 1));
			else if (pick >= 80)
				e.seg = SEG_W'($urandom_range(7));
			send_command(op, e);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cmd_bus.valid        = 1'b0;
		cmd_bus.func         = OP_NOP;
		cmd_bus.seg_addr     = '0;
		cmd_bus.interval     = '0;
		cmd_bus.repeat_times = '0;
		cmd_bus.play_kind    = '0;
		cmd_bus.priority_req = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_commands();
		wait_replies_drained();

		// Light command gaps against a busy receiver.
		cmd_idle_pct = 13;
		rsp_idle_pct = 59;
		random_commands(600);
		wait_replies_drained();

		// Now a sparse sender and an eager receiver.
		cmd_idle_pct = 59;
		rsp_idle_pct = 13;
		random_commands(600);
		wait_replies_drained();

		// Back to back on both sides.
		cmd_idle_pct = 0;
		rsp_idle_pct = 0;
		random_commands(600);
		wait_replies_drained();

		// Let any stray response show up before the verdict.
		repeat (32) @(negedge clk);
		if (playlist.mismatch_count == 0 && playlist.replies_due.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
